/* hw/rtl/assert_macros.svh */
// Assertion helpers for the RTL files (included by lqr_dpath.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check a property at every rising edge, ignored while reset is asserted.
`define CHK_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check a property at every rising edge, reset included.
`define CHK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CHK_AT(lbl, clk, rstn, prop, msg)
`define CHK_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* hw/rtl/lqr_pkg.sv */
package lqr_pkg;

    localparam int QUEUE_DEPTH_DEF = 128;
    localparam int DATA_W          = 32;
    localparam int COUNT_W         = 8;

    // Command codes
    localparam logic [1:0] CMD_PUSH    = 2'd0;
    localparam logic [1:0] CMD_POP     = 2'd1;
    localparam logic [1:0] CMD_REVERSE = 2'd2;

    // Status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]               command;
        logic signed [DATA_W-1:0] push_value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] pop_value;
        logic [COUNT_W-1:0]       element_count;
        logic                     is_empty;
        logic                     is_full;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_RD,
        S_REV_FILL,
        S_REV_BACK,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic pop_cap;
        logic fill;
        logic back;
        logic load_out;
    } t_dp_ctl;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] command;
        logic       empty;
        logic       walk_last;
        logic       out_free;
    } t_dp_sts;

endpackage

/* hw/rtl/lqr_ctrl.sv */
module lqr_ctrl
    import lqr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_dp_ctl o_ctl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_sts.command == CMD_POP && !i_sts.empty) begin
                        n_state = S_POP_RD;
                    end else if (i_sts.command == CMD_REVERSE && !i_sts.empty) begin
                        n_state = S_REV_FILL;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_POP_RD: begin
                n_state = S_DONE;
            end
            S_REV_FILL: begin
                if (i_sts.walk_last) begin
                    n_state = S_REV_BACK;
                end
            end
            S_REV_BACK: begin
                if (i_sts.walk_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_ctl          = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_ctl.accept = i_in_valid;
            end
            S_POP_RD: begin
                o_ctl.pop_cap = 1'b1;
            end
            S_REV_FILL: begin
                o_ctl.fill = 1'b1;
            end
            S_REV_BACK: begin
                o_ctl.back = 1'b1;
            end
            S_DONE: begin
                o_ctl.load_out = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* hw/rtl/lqr_dpath.sv */
`include "assert_macros.svh"

module lqr_dpath
    import lqr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_ctl   i_ctl,
    input  t_in_word  i_in_word,
    input  logic      i_out_ready,
    output t_dp_sts   o_sts,
    output logic      o_out_valid,
    output t_out_word o_out_word
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(QUEUE_DEPTH - 1);

    logic [DATA_W-1:0] r_slot    [QUEUE_DEPTH];
    logic [DATA_W-1:0] r_scratch [QUEUE_DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic [DATA_W-1:0] r_sc_rd_data;

    logic [IDX_W-1:0]  r_head;
    logic [IDX_W-1:0]  r_tail;
    logic              r_empty;
    logic [IDX_W:0]    r_walk;
    logic [IDX_W:0]    r_len;
    logic [1:0]        r_status;
    logic [DATA_W-1:0] r_popped;
    logic              r_out_valid;
    t_out_word         r_out_word;

    logic              w_at_last;
    logic [IDX_W:0]    w_span;
    logic [IDX_W:0]    w_count;
    logic              w_walk_last;
    logic              w_push_ok;
    logic              w_is_push;
    logic              w_is_pop;

    logic              w_slot_we;
    logic [IDX_W-1:0]  w_slot_wa;
    logic [DATA_W-1:0] w_slot_wd;
    logic [IDX_W-1:0]  w_slot_ra;
    logic              w_sc_we;
    logic [IDX_W-1:0]  w_walk_prev;

    assign w_at_last   = !r_empty && (r_tail == LAST_SLOT);
    assign w_span      = {1'b0, r_tail} - {1'b0, r_head} + (IDX_W+1)'(1);
    assign w_count     = r_empty ? '0 : w_span;
    assign w_walk_last = (r_walk == r_len);
    assign w_is_push   = (i_in_word.command == CMD_PUSH);
    assign w_is_pop    = (i_in_word.command == CMD_POP);
    assign w_push_ok   = r_empty || !w_at_last;
    assign w_walk_prev = IDX_W'(r_walk - (IDX_W+1)'(1));

    // Memory ports: a push writes at accept, the copy-back writes one word behind the walk
    always_comb begin
        w_slot_we = 1'b0;
        w_slot_wa = w_walk_prev;
        w_slot_wd = r_sc_rd_data;
        if (i_ctl.accept) begin
            w_slot_we = w_is_push && w_push_ok;
            w_slot_wa = r_empty ? '0 : r_tail + IDX_W'(1);
            w_slot_wd = i_in_word.push_value;
        end else if (i_ctl.back) begin
            w_slot_we = (r_walk != '0);
        end
    end

    assign w_slot_ra = i_ctl.fill ? (r_tail - r_walk[IDX_W-1:0]) : r_head;
    assign w_sc_we   = i_ctl.fill && (r_walk != '0);

    always_ff @(posedge i_clk) begin
        if (w_slot_we) begin
            r_slot[w_slot_wa] <= w_slot_wd;
        end
        r_rd_data <= r_slot[w_slot_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_sc_we) begin
            r_scratch[w_walk_prev] <= r_rd_data;
        end
        r_sc_rd_data <= r_scratch[r_walk[IDX_W-1:0]];
    end

    // Indices, flags and walk counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
            r_walk  <= '0;
            r_len   <= '0;
        end else if (i_ctl.accept) begin
            r_walk <= '0;
            r_len  <= w_span;
            if (w_is_push) begin
                if (r_empty) begin
                    r_head  <= '0;
                    r_tail  <= '0;
                    r_empty <= 1'b0;
                end else if (!w_at_last) begin
                    r_tail <= r_tail + IDX_W'(1);
                end
            end else if (w_is_pop && !r_empty) begin
                if (r_head == r_tail) begin
                    r_head  <= '0;
                    r_tail  <= '0;
                    r_empty <= 1'b1;
                end else begin
                    r_head <= r_head + IDX_W'(1);
                end
            end
        end else if (i_ctl.fill) begin
            r_walk <= w_walk_last ? '0 : r_walk + (IDX_W+1)'(1);
        end else if (i_ctl.back) begin
            if (w_walk_last) begin
                r_head <= '0;
                r_tail <= IDX_W'(r_len - (IDX_W+1)'(1));
            end else begin
                r_walk <= r_walk + (IDX_W+1)'(1);
            end
        end
    end

    // Result of the current word
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_status <= ST_DONE;
            r_popped <= '0;
            if (w_is_push && !w_push_ok) begin
                r_status <= ST_FULL;
            end else if (w_is_pop && r_empty) begin
                r_status <= ST_EMPTY;
                r_popped <= '1;
            end
        end else if (i_ctl.pop_cap) begin
            r_popped <= r_rd_data;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            r_out_word.status        <= r_status;
            r_out_word.pop_value     <= r_popped;
            r_out_word.element_count <= COUNT_W'(w_count);
            r_out_word.is_empty      <= r_empty;
            r_out_word.is_full       <= w_at_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_word      = r_out_word;
    assign o_sts.command   = i_in_word.command;
    assign o_sts.empty     = r_empty;
    assign o_sts.walk_last = w_walk_last;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    `CHK_AT(a_empty_idx, i_clk, i_rst_n, r_empty |-> (r_head == '0 && r_tail == '0), "indices not cleared while empty")
    `CHK_AT(a_head_le_tail, i_clk, i_rst_n, !r_empty |-> (r_head <= r_tail), "head beyond tail")
    `CHK_AT(a_walk_range, i_clk, i_rst_n, (i_ctl.fill || i_ctl.back) |-> (r_walk <= r_len), "walk past held words")
    `CHK_AT(a_load_free, i_clk, i_rst_n, i_ctl.load_out |-> (!r_out_valid || i_out_ready), "result overwritten")

endmodule

/* hw/rtl/linear_queue_with_reverse.sv */
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_in_word  (t_in_word)
// output    out        o_out_valid / i_out_ready  o_out_word (t_out_word)
//
// One word at a time. Push, refused pop, no-op and empty reverse go from accept to the done
// state and the output register; a pop adds one registered read of the slot memory.
// Reverse of n held words: one walk copies them backwards into a scratch memory, a second
// copies them back from slot 0, one word a cycle each.
// Reset is synchronous, active low; the queue comes out empty and needs no clearing pass.
// A stalled output holds its result; the next word is taken and worked, then waits for it.
module linear_queue_with_reverse
    import lqr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    t_dp_ctl w_ctl;
    t_dp_sts w_sts;

    lqr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_ctl      (w_ctl)
    );

    lqr_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_in_word   (i_in_word),
        .i_out_ready (i_out_ready),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule
